// ===== hw/rtl/mcp_pkg.sv =====
// Shared types, constants and helpers of the median-cut palette builder.
package mcp_pkg;

   localparam int PIX_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int MAX_OUT = 16;
   localparam int IDX_W   = 4;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } mcp_chan_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mcp_div_stat_type;

   function automatic logic [CHAN_W-1:0] chan_of(input logic [PIX_W-1:0] px,
                                                 input mcp_chan_type sel);
      logic [CHAN_W-1:0] v;
      case (sel)
         CH_RED:   v = px[23:16];
         CH_GREEN: v = px[15:8];
         default:  v = px[7:0];
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/mcp_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
module mcp_ram #(
   parameter int DATA_WIDTH = 24,
   parameter int DEPTH      = 256
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);
   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mcp_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module mcp_div #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 15
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          dividend,
   input  logic [DEN_W-1:0]          divisor,
   output logic [NUM_W-1:0]          quotient,
   output mcp_pkg::mcp_div_stat_type stat
);
   import mcp_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

// ===== hw/rtl/median_cut_palette.sv =====
// Top level of the median-cut palette builder: sequencer, box queue and pixel stores.
//
// Pixels stream in on the req_ channel at one transfer per cycle and are written
// into an on-chip pixel store of MAX_PIXELS entries; pixels beyond that are dropped.
// A transfer with req_tlast set ends the frame and req_tready drops until the
// palette has been delivered. The palette is built by median cut: a queue of boxes
// starts with one box of all pixels, and each round pops the head box, finds the
// channel with the widest range (ties go to red, then green, then blue), sorts the
// box stably on that channel with a counting sort and pushes both halves of
// floor(size/2) pixels. Rounds stop when the queue holds PALETTE_SIZE boxes. Each
// of the first min(PALETTE_SIZE, 16) boxes then yields one rsp_ transfer with the
// truncated mean color, computed by one shared restoring divider. A round on a box
// of two or more pixels runs a range scan, a histogram clear, a count, a prefix sum,
// a scatter and a copy back; a box of fewer than two pixels skips all of them. Each
// palette entry is summed over its box and, for a box that is not empty, divided
// three times, once per channel, before its result waits for rsp_tready.
module median_cut_palette #(
   parameter int PALETTE_SIZE = 16,
   parameter int MAX_PIXELS   = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic        req_tlast,   // last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16],
                                    // entry_index[27:24], zero fill[31:28]
   output logic        rsp_tuser,   // empty_box
   output logic        rsp_tlast    // last_entry
);
   import mcp_pkg::*;

   localparam int AW    = $clog2(MAX_PIXELS);
   localparam int CW    = $clog2(MAX_PIXELS + 1);
   localparam int SW    = CW + CHAN_W;
   localparam int QD    = 2 * PALETTE_SIZE;
   localparam int QAW   = $clog2(QD);
   localparam int QHW   = $clog2(QD + 1);
   localparam int NOUT  = (PALETTE_SIZE < MAX_OUT) ? PALETTE_SIZE : MAX_OUT;
   localparam int EW    = $clog2(MAX_OUT + 1);
   localparam int HBINS = 256;

   typedef enum logic [24:0] {
      ST_LOAD  = 25'h0000001,
      ST_INIT  = 25'h0000002,
      ST_POP   = 25'h0000004,
      ST_POPW  = 25'h0000008,
      ST_RANGE = 25'h0000010,
      ST_HCLR  = 25'h0000020,
      ST_CNT_A = 25'h0000040,
      ST_CNT_B = 25'h0000080,
      ST_CNT_C = 25'h0000100,
      ST_PFX_A = 25'h0000200,
      ST_PFX_B = 25'h0000400,
      ST_SCT_A = 25'h0000800,
      ST_SCT_B = 25'h0001000,
      ST_SCT_C = 25'h0002000,
      ST_CPY_A = 25'h0004000,
      ST_CPY_B = 25'h0008000,
      ST_PUSH1 = 25'h0010000,
      ST_PUSH2 = 25'h0020000,
      ST_MQ    = 25'h0040000,
      ST_MQW   = 25'h0080000,
      ST_MSUM  = 25'h0100000,
      ST_DIVR  = 25'h0200000,
      ST_DIVG  = 25'h0400000,
      ST_DIVB  = 25'h0800000,
      ST_EMIT  = 25'h1000000
   } mcp_state_type;

   mcp_state_type state_ff, state_in;

   // Control registers.
   logic [CW-1:0]   cnt_ff, cnt_in;        // pixels stored in this frame
   logic [QHW-1:0]  head_ff, head_in;
   logic [QHW-1:0]  tail_ff, tail_in;
   logic [QHW-1:0]  qcnt_ff, qcnt_in;
   logic [CW-1:0]   idx_ff, idx_in;        // pixel position inside the current box
   logic [8:0]      k_ff, k_in;            // histogram bin
   logic [EW-1:0]   e_ff, e_in;            // palette entry being produced
   logic            rd_vld_ff, rd_vld_in;  // a pixel read is in flight

   // Payload registers.
   logic [CW-1:0]     start_ff, start_in;
   logic [CW-1:0]     size_ff, size_in;
   logic [CW-1:0]     acc_ff, acc_in;
   logic [CHAN_W-1:0] mx_ff [3];
   logic [CHAN_W-1:0] mx_in [3];
   logic [CHAN_W-1:0] mn_ff [3];
   logic [CHAN_W-1:0] mn_in [3];
   mcp_chan_type      sel_ff, sel_in;
   logic [CHAN_W-1:0] key_ff, key_in;
   logic [PIX_W-1:0]  px_ff, px_in;
   logic [SW-1:0]     sum_ff [3];
   logic [SW-1:0]     sum_in [3];
   logic [CHAN_W-1:0] mean_ff [3];
   logic [CHAN_W-1:0] mean_in [3];
   logic              empty_ff, empty_in;

   // Memory ports.
   logic              st_we;
   logic [AW-1:0]     st_waddr, st_raddr;
   logic [PIX_W-1:0]  st_wdata, st_q;
   logic              sb_we;
   logic [AW-1:0]     sb_waddr;
   logic [PIX_W-1:0]  sb_q;
   logic              h_we;
   logic [7:0]        h_waddr, h_raddr;
   logic [CW-1:0]     h_wdata, h_q;
   logic              q_we;
   logic [QAW-1:0]    q_waddr, q_raddr;
   logic [2*CW-1:0]   q_wdata, q_q;

   // Shared divider.
   logic              div_start;
   logic [SW-1:0]     div_num, div_quo;
   mcp_div_stat_type  div_stat;

   logic [CW-1:0]     half;
   logic [CW-1:0]     box_addr;
   logic              issue;
   logic              scan_done;
   logic              last_px;
   logic [CHAN_W-1:0] rng [3];
   logic              req_xfer, rsp_xfer;

   assign half      = size_ff >> 1;
   assign box_addr  = start_ff + idx_ff;
   assign issue     = idx_ff < size_ff;
   assign scan_done = !issue && !rd_vld_ff;
   assign last_px   = (idx_ff + CW'(1)) == size_ff;
   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rng[c] = mx_ff[c] - mn_ff[c];
      end
   end

   // Memory address and data selection. Every pixel-store access to a box goes through start + idx.
   always_comb begin
      st_raddr = box_addr[AW-1:0];
      st_we    = 1'b0;
      st_waddr = box_addr[AW-1:0];
      st_wdata = sb_q;
      if (state_ff == ST_LOAD) begin
         // The store keeps red in the top byte and blue in the bottom byte.
         st_we    = req_xfer && (cnt_ff < CW'(MAX_PIXELS));
         st_waddr = cnt_ff[AW-1:0];
         st_wdata = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      end else if (state_ff == ST_CPY_B) begin
         st_we = 1'b1;
      end

      sb_we    = (state_ff == ST_SCT_C);
      sb_waddr = h_q[AW-1:0];

      h_raddr = k_ff[7:0];
      if (state_ff == ST_CNT_B || state_ff == ST_SCT_B) begin
         h_raddr = chan_of(st_q, sel_ff);
      end
      h_we    = 1'b0;
      h_waddr = key_ff;
      h_wdata = h_q + CW'(1);
      case (state_ff)
         ST_HCLR: begin
            h_we    = 1'b1;
            h_waddr = k_ff[7:0];
            h_wdata = '0;
         end
         ST_CNT_C, ST_SCT_C: begin
            h_we = 1'b1;
         end
         ST_PFX_B: begin
            h_we    = 1'b1;
            h_waddr = k_ff[7:0];
            h_wdata = acc_ff;
         end
         default: begin
            h_we = 1'b0;
         end
      endcase

      q_raddr = head_ff[QAW-1:0];
      if (state_ff == ST_MQ) begin
         q_raddr = QAW'(head_ff + QHW'(e_ff));
      end
      q_we    = 1'b0;
      q_waddr = tail_ff[QAW-1:0];
      q_wdata = {start_ff, half};
      case (state_ff)
         ST_INIT: begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = {CW'(0), cnt_ff};
         end
         ST_PUSH1: begin
            q_we = 1'b1;
         end
         ST_PUSH2: begin
            q_we    = 1'b1;
            q_wdata = {CW'(start_ff + half), half};
         end
         default: begin
            q_we = 1'b0;
         end
      endcase
   end

   // Divider requests: red when summing ends, then green and blue as each finishes.
   always_comb begin
      div_start = 1'b0;
      div_num   = sum_ff[0];
      case (state_ff)
         ST_MSUM: begin
            div_start = scan_done && (size_ff != '0);
         end
         ST_DIVR: begin
            div_start = div_stat.done;
            div_num   = sum_ff[1];
         end
         ST_DIVG: begin
            div_start = div_stat.done;
            div_num   = sum_ff[2];
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      qcnt_in   = qcnt_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      rd_vld_in = rd_vld_ff;
      start_in  = start_ff;
      size_in   = size_ff;
      acc_in    = acc_ff;
      sel_in    = sel_ff;
      key_in    = key_ff;
      px_in     = px_ff;
      empty_in  = empty_ff;
      for (int c = 0; c < 3; c++) begin
         mx_in[c]   = mx_ff[c];
         mn_in[c]   = mn_ff[c];
         sum_in[c]  = sum_ff[c];
         mean_in[c] = mean_ff[c];
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (cnt_ff < CW'(MAX_PIXELS)) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            head_in = '0;
            tail_in = QHW'(1);
            qcnt_in = QHW'(1);
            e_in    = '0;
            state_in = (PALETTE_SIZE > 1) ? ST_POP : ST_MQ;
         end
         ST_POP: begin
            state_in = ST_POPW;
         end
         ST_POPW: begin
            start_in  = q_q[2*CW-1:CW];
            size_in   = q_q[CW-1:0];
            head_in   = head_ff + QHW'(1);
            qcnt_in   = qcnt_ff - QHW'(1);
            idx_in    = '0;
            rd_vld_in = 1'b0;
            for (int c = 0; c < 3; c++) begin
               mx_in[c] = '0;
               mn_in[c] = '1;
            end
            // A box of fewer than two pixels needs no sort.
            state_in = (q_q[CW-1:0] > CW'(1)) ? ST_RANGE : ST_PUSH1;
         end
         ST_RANGE: begin
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               for (int c = 0; c < 3; c++) begin
                  if (chan_of(st_q, mcp_chan_type'(c)) > mx_ff[c]) begin
                     mx_in[c] = chan_of(st_q, mcp_chan_type'(c));
                  end
                  if (chan_of(st_q, mcp_chan_type'(c)) < mn_ff[c]) begin
                     mn_in[c] = chan_of(st_q, mcp_chan_type'(c));
                  end
               end
            end
            if (scan_done) begin
               if (rng[0] >= rng[1] && rng[0] >= rng[2]) begin
                  sel_in = CH_RED;
               end else if (rng[1] >= rng[2]) begin
                  sel_in = CH_GREEN;
               end else begin
                  sel_in = CH_BLUE;
               end
               k_in     = '0;
               state_in = ST_HCLR;
            end
         end
         ST_HCLR: begin
            k_in = k_ff + 9'd1;
            if (k_ff == 9'(HBINS - 1)) begin
               idx_in   = '0;
               state_in = ST_CNT_A;
            end
         end
         ST_CNT_A: begin
            state_in = ST_CNT_B;
         end
         ST_CNT_B: begin
            key_in   = chan_of(st_q, sel_ff);
            state_in = ST_CNT_C;
         end
         ST_CNT_C: begin
            idx_in = idx_ff + CW'(1);
            if (last_px) begin
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_PFX_A;
            end else begin
               state_in = ST_CNT_A;
            end
         end
         ST_PFX_A: begin
            state_in = ST_PFX_B;
         end
         ST_PFX_B: begin
            acc_in = acc_ff + h_q;
            k_in   = k_ff + 9'd1;
            if (k_ff == 9'(HBINS - 1)) begin
               idx_in   = '0;
               state_in = ST_SCT_A;
            end else begin
               state_in = ST_PFX_A;
            end
         end
         ST_SCT_A: begin
            state_in = ST_SCT_B;
         end
         ST_SCT_B: begin
            key_in   = chan_of(st_q, sel_ff);
            px_in    = st_q;
            state_in = ST_SCT_C;
         end
         ST_SCT_C: begin
            idx_in = idx_ff + CW'(1);
            if (last_px) begin
               idx_in   = '0;
               state_in = ST_CPY_A;
            end else begin
               state_in = ST_SCT_A;
            end
         end
         ST_CPY_A: begin
            state_in = ST_CPY_B;
         end
         ST_CPY_B: begin
            idx_in   = idx_ff + CW'(1);
            state_in = last_px ? ST_PUSH1 : ST_CPY_A;
         end
         ST_PUSH1: begin
            tail_in  = tail_ff + QHW'(1);
            qcnt_in  = qcnt_ff + QHW'(1);
            state_in = ST_PUSH2;
         end
         ST_PUSH2: begin
            tail_in = tail_ff + QHW'(1);
            qcnt_in = qcnt_ff + QHW'(1);
            if ((qcnt_ff + QHW'(1)) < QHW'(PALETTE_SIZE)) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_MQ;
            end
         end
         ST_MQ: begin
            state_in = ST_MQW;
         end
         ST_MQW: begin
            start_in  = q_q[2*CW-1:CW];
            size_in   = q_q[CW-1:0];
            idx_in    = '0;
            rd_vld_in = 1'b0;
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = '0;
            end
            state_in = ST_MSUM;
         end
         ST_MSUM: begin
            rd_vld_in = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               for (int c = 0; c < 3; c++) begin
                  sum_in[c] = sum_ff[c] + SW'(chan_of(st_q, mcp_chan_type'(c)));
               end
            end
            if (scan_done) begin
               if (size_ff == '0) begin
                  empty_in = 1'b1;
                  for (int c = 0; c < 3; c++) begin
                     mean_in[c] = '0;
                  end
                  state_in = ST_EMIT;
               end else begin
                  empty_in = 1'b0;
                  state_in = ST_DIVR;
               end
            end
         end
         ST_DIVR: begin
            if (div_stat.done) begin
               mean_in[0] = div_quo[CHAN_W-1:0];
               state_in   = ST_DIVG;
            end
         end
         ST_DIVG: begin
            if (div_stat.done) begin
               mean_in[1] = div_quo[CHAN_W-1:0];
               state_in   = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_stat.done) begin
               mean_in[2] = div_quo[CHAN_W-1:0];
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               e_in = e_ff + EW'(1);
               if (e_ff == EW'(NOUT - 1)) begin
                  // Frame done: clear the store count and the queue for the next frame.
                  cnt_in   = '0;
                  head_in  = '0;
                  tail_in  = '0;
                  qcnt_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_MQ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         cnt_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         qcnt_ff   <= '0;
         idx_ff    <= '0;
         k_ff      <= '0;
         e_ff      <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         qcnt_ff   <= qcnt_in;
         idx_ff    <= idx_in;
         k_ff      <= k_in;
         e_ff      <= e_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      size_ff  <= size_in;
      acc_ff   <= acc_in;
      sel_ff   <= sel_in;
      key_ff   <= key_in;
      px_ff    <= px_in;
      empty_ff <= empty_in;
      for (int c = 0; c < 3; c++) begin
         mx_ff[c]   <= mx_in[c];
         mn_ff[c]   <= mn_in[c];
         sum_ff[c]  <= sum_in[c];
         mean_ff[c] <= mean_in[c];
      end
   end

   // Pixel store, sort buffer, histogram and box queue.
   mcp_ram #(.DATA_WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_q)
   );

   mcp_ram #(.DATA_WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_sortbuf (
      .clock   (clock),
      .wr_en   (sb_we),
      .wr_addr (sb_waddr),
      .wr_data (px_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (sb_q)
   );

   mcp_ram #(.DATA_WIDTH(CW), .DEPTH(HBINS)) u_hist (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_q)
   );

   mcp_ram #(.DATA_WIDTH(2 * CW), .DEPTH(QD)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_q)
   );

   mcp_div #(.NUM_W(SW), .DEN_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (size_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Ports.
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {4'd0, e_ff[IDX_W-1:0], mean_ff[2], mean_ff[1], mean_ff[0]};
   assign rsp_tuser  = empty_ff;
   assign rsp_tlast  = (e_ff == EW'(NOUT - 1));

   // The queue never holds more boxes than the palette needs.
   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QHW'(PALETTE_SIZE))
      else $error("box queue count exceeds palette size");

   // The tail always sits at head plus count.
   a_queue_ptrs: assert property (@(posedge clock) disable iff (reset)
      tail_ff == QHW'(head_ff + qcnt_ff))
      else $error("box queue pointers out of step");

   // The final palette transfer returns the block to loading with an empty store.
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> (state_ff == ST_LOAD && cnt_ff == '0 && qcnt_ff == '0))
      else $error("frame did not restart after last entry");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVR || state_ff == ST_DIVG || state_ff == ST_DIVB))
      else $error("divider finished outside a divide step");

   // Pixels are never taken while a result is offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and output active together");
endmodule

// ===== sim/median_cut_palette_checker.sv =====
// Checker for the median-cut palette builder: predicts every palette and compares it.
`timescale 1ns / 1ps

module median_cut_palette_checker #(
   parameter int PALETTE_SIZE = 16,
   parameter int MAX_PIXELS   = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_entries,
   output int          palettes_seen,
   output int          entries_seen
);
   import mcp_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] index;
      logic       empty;
      logic       last;
   } palette_entry_t;

   localparam int QDEPTH = 2 * PALETTE_SIZE;
   localparam int NOUT = (PALETTE_SIZE < MAX_OUT) ? PALETTE_SIZE : MAX_OUT;

   logic [PIX_W-1:0] frame_pixels [MAX_PIXELS];
   int               frame_count;
   int               box_start [QDEPTH];
   int               box_len   [QDEPTH];
   int               q_head, q_count;
   palette_entry_t   expected_entries [$];

   assign pending_entries = expected_entries.size();

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void push_box(input int start, input int len);
      if (q_head + q_count < QDEPTH) begin
         box_start[q_head + q_count] = start;
         box_len[q_head + q_count] = len;
         q_count++;
      end
   endfunction

   // Pops the head box, sorts it stably on its widest channel and queues both halves.
   function automatic void split_box();
      int start, len, half;
      int lo [3], hi [3], span [3];
      mcp_chan_type widest;
      logic [PIX_W-1:0] sorted [$];
      start = box_start[q_head];
      len = box_len[q_head];
      half = len / 2;
      q_head++;
      q_count--;
      if (len > 0) begin
         for (int c = 0; c < 3; c++) begin
            lo[c] = 255;
            hi[c] = 0;
         end
         for (int i = 0; i < len; i++) begin
            for (int c = 0; c < 3; c++) begin
               int v;
               v = chan_of(frame_pixels[start + i], mcp_chan_type'(c));
               if (v > hi[c]) hi[c] = v;
               if (v < lo[c]) lo[c] = v;
            end
         end
         for (int c = 0; c < 3; c++) span[c] = hi[c] - lo[c];
         if (span[0] >= span[1] && span[0] >= span[2]) widest = CH_RED;
         else if (span[1] >= span[2]) widest = CH_GREEN;
         else widest = CH_BLUE;
         // Bucket by value in ascending order, which keeps arrival order within a value.
         for (int v = 0; v < 256; v++) begin
            for (int i = 0; i < len; i++) begin
               if (chan_of(frame_pixels[start + i], widest) == v)
                  sorted.push_back(frame_pixels[start + i]);
            end
         end
         for (int i = 0; i < len; i++) frame_pixels[start + i] = sorted[i];
      end
      push_box(start, half);
      push_box(start + half, half);
   endfunction

   function automatic void predict_palette();
      palette_entry_t e;
      q_head = 0;
      q_count = 0;
      push_box(0, frame_count);
      while (q_count < PALETTE_SIZE) split_box();
      for (int n = 0; n < NOUT; n++) begin
         int start, len, sr, sg, sb;
         start = box_start[q_head + n];
         len = box_len[q_head + n];
         sr = 0;
         sg = 0;
         sb = 0;
         for (int i = 0; i < len; i++) begin
            sr += frame_pixels[start + i][23:16];
            sg += frame_pixels[start + i][15:8];
            sb += frame_pixels[start + i][7:0];
         end
         e.red = (len > 0) ? 8'(sr / len) : 8'd0;
         e.green = (len > 0) ? 8'(sg / len) : 8'd0;
         e.blue = (len > 0) ? 8'(sb / len) : 8'd0;
         e.empty = (len == 0);
         e.index = 4'(n);
         e.last = (n == NOUT - 1);
         expected_entries.push_back(e);
      end
      frame_count = 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         frame_count = 0;
         palettes_seen <= 0;
         entries_seen <= 0;
         expected_entries.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            // Channels arrive red, green, blue from the low byte; stored as red in the top byte.
            if (frame_count < MAX_PIXELS) begin
               frame_pixels[frame_count] = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
               frame_count++;
            end
            if (req_tlast) begin
               predict_palette();
               palettes_seen <= palettes_seen + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            palette_entry_t want;
            entries_seen <= entries_seen + 1;
            if (expected_entries.size() == 0) begin
               report_mismatch($sformatf("unexpected entry tdata=%h", rsp_tdata));
            end else begin
               want = expected_entries.pop_front();
               if (rsp_tdata[7:0] !== want.red)
                  report_mismatch($sformatf("entry %0d red %h want %h",
                                            want.index, rsp_tdata[7:0], want.red));
               if (rsp_tdata[15:8] !== want.green)
                  report_mismatch($sformatf("entry %0d green %h want %h",
                                            want.index, rsp_tdata[15:8], want.green));
               if (rsp_tdata[23:16] !== want.blue)
                  report_mismatch($sformatf("entry %0d blue %h want %h",
                                            want.index, rsp_tdata[23:16], want.blue));
               if (rsp_tdata[27:24] !== want.index)
                  report_mismatch($sformatf("entry index %0d want %0d",
                                            rsp_tdata[27:24], want.index));
               if (rsp_tdata[31:28] !== 4'd0)
                  report_mismatch($sformatf("entry %0d fill bits %h", want.index,
                                            rsp_tdata[31:28]));
               if (rsp_tuser !== want.empty)
                  report_mismatch($sformatf("entry %0d empty flag %b want %b",
                                            want.index, rsp_tuser, want.empty));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("entry %0d last flag %b want %b",
                                            want.index, rsp_tlast, want.last));
            end
         end
      end
   end

endmodule

// ===== sim/tb_median_cut_palette.sv =====
// Testbench top for the median-cut palette builder: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_median_cut_palette;

   localparam int PALETTE_SIZE = 16;
   localparam int MAX_PIXELS   = 16384;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int fail_count, pending_entries, palettes_seen, entries_seen;
   int pixels_sent;
   bit sink_calm;   // no stalls on the result side in the final stretch

   median_cut_palette #(
      .PALETTE_SIZE(PALETTE_SIZE),
      .MAX_PIXELS  (MAX_PIXELS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   median_cut_palette_checker #(
      .PALETTE_SIZE(PALETTE_SIZE),
      .MAX_PIXELS  (MAX_PIXELS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_entries(pending_entries),
      .palettes_seen  (palettes_seen),
      .entries_seen   (entries_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Sends one pixel and holds it until the block takes the transfer. The data lanes
   // carry red in the low byte, then green, then blue. An optional idle burst comes
   // first so that gaps land both inside frames and right after a palette.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last, input bit may_idle);
      if (may_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   // Random content for one frame; some frames use a narrow palette so that ties
   // between channel ranges come up often.
   task automatic send_random_frame(input int len, input bit narrow, input bit may_idle);
      logic [7:0] r, g, b;
      for (int i = 0; i < len; i++) begin
         r = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
         g = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
         b = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
         send_pixel(r, g, b, i == len - 1, may_idle);
      end
      req_tvalid <= 1'b0;
   endtask

   // Result-side back-pressure: random bursts of stalls, with calm stretches.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!sink_calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   // The timer below bounds a hung run.
   initial begin
      #40ms;
      $display("tb_median_cut_palette: errors");
      $finish;
   end

   initial begin
      int settle;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      reset       = 1'b1;
      sink_calm   = 1'b0;
      pixels_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a lone pixel drops out at the first split, so all sixteen boxes are empty.
      send_pixel(8'hff, 8'h00, 8'h80, 1'b1, 1'b0);
      // Ties: equal ranges on all channels, then green over blue.
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_pixel(8'hff, 8'hff, 8'hff, 1'b1, 1'b0);
      send_pixel(8'h10, 8'h00, 8'h00, 1'b0, 1'b0);
      send_pixel(8'h10, 8'hf0, 8'h00, 1'b0, 1'b0);
      send_pixel(8'h10, 8'h20, 8'hf0, 1'b1, 1'b0);
      // Blue widest with an odd count, so the last pixel after sorting drops out.
      send_pixel(8'h55, 8'haa, 8'h01, 1'b0, 1'b0);
      send_pixel(8'h55, 8'haa, 8'hfe, 1'b0, 1'b0);
      send_pixel(8'h56, 8'hab, 8'h7f, 1'b0, 1'b0);
      send_pixel(8'h01, 8'h02, 8'h03, 1'b0, 1'b0);
      send_pixel(8'haa, 8'h55, 8'h80, 1'b1, 1'b0);
      // Sixteen pixels, one per box, walking a bit across the red and green lanes, with a ramp on blue.
      for (int i = 0; i < 16; i++)
         send_pixel(8'(1 << (i % 8)), 8'(8'h80 >> (i % 8)), 8'(i * 17), i == 15, 1'b0);
      req_tvalid <= 1'b0;

      // Random: mostly small frames, a few larger ones.
      while (pixels_sent < 330) begin
         if ($urandom_range(0, 9) == 0)
            send_random_frame($urandom_range(32, 64), $urandom_range(0, 1), 1'b1);
         else
            send_random_frame($urandom_range(1, 20), $urandom_range(0, 2) == 0, 1'b1);
      end
      // Final stretch with no idling on either side.
      sink_calm = 1'b1;
      while (pixels_sent < 380) send_random_frame($urandom_range(1, 24), 1'b0, 1'b0);

      while (pending_entries != 0) @(posedge clock);
      settle = 0;
      while (settle < 200) begin
         @(posedge clock);
         settle++;
      end

      $display("Sent %0d pixels in %0d frames; checked %0d palette entries.",
               pixels_sent, palettes_seen, entries_seen);
      if (fail_count == 0) begin
         $display("tb_median_cut_palette: clean");
      end else begin
         $display("tb_median_cut_palette: errors");
      end
      $finish;
   end

endmodule
